[hdl/pfl_pkg.sv]
// shared constants, codes and types for the page free list allocator
`timescale 1ns / 1ps
package pfl_pkg;

  localparam int ADDR_W        = 32;
  localparam int PFL_PAGE_SIZE = 4096;
  localparam int PFL_NUM_PAGES = 1024;

  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RANGE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_PAGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END   = 2'd3;

  localparam logic [ADDR_W-1:0] LOW_LIMIT_RST   = 32'd0;
  localparam logic [ADDR_W-1:0] UPPER_LIMIT_RST = 32'd4294963200;
  localparam logic [ADDR_W-1:0] RANGE_START_RST = 32'd0;
  localparam logic [ADDR_W-1:0] RANGE_END_RST   = 32'd0;

  localparam int RES_W      = ADDR_W + 1 + STAT_W;
  localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

  typedef struct packed {
    logic [ADDR_W-1:0] low_limit;
    logic [ADDR_W-1:0] upper_limit;
    logic [ADDR_W-1:0] range_start;
    logic [ADDR_W-1:0] range_end;
  } pfl_cfg_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              got_page;
    logic [ADDR_W-1:0] alloc_addr;
  } pfl_result_t;

endpackage

[hdl/page_free_list_allocator.sv]
// Page-frame allocator keeping free pages on a LIFO list chained through a
// next-link table with one entry per page. Allocate (tuser 0) pops the head
// page, free (tuser 1) checks alignment, the low and upper limits and the
// table window before pushing, and range free (tuser 2) frees every whole
// page of the configured range in ascending order. Allocate passes through an
// allocate state and free through a free state before the done state, where
// the result waits until the output register can take it; an allocate on an
// empty list and an unused action go straight to the done state. Range free
// stays in the walk state while pages remain before the done state, since the
// range walk pushes one page per cycle through the single write port of the
// link table and the shared address checker. One request is in work at a
// time; a finished result waits in the output register while the next request
// is taken. The user must write configuration only while the block is idle;
// the block itself does not enforce it. PAGE_SIZE must be a power of two.
`timescale 1ns / 1ps
module page_free_list_allocator #(
  parameter int PAGE_SIZE = pfl_pkg::PFL_PAGE_SIZE,
  parameter int NUM_PAGES = pfl_pkg::PFL_NUM_PAGES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pfl_pkg::ADDR_W-1:0]     s_axis_tdata,   // page_addr
  input  logic [pfl_pkg::ACT_W-1:0]      s_axis_tuser,   // action
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [pfl_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // alloc_addr, got_page, status, zero pad
  input  logic                           cfg_we_i,
  input  logic [pfl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pfl_pkg::ADDR_W-1:0]     cfg_wdata_i
);
  import pfl_pkg::*;

  pfl_cfg_t    cfg_q;
  pfl_result_t res;
  pfl_result_t out_q;
  logic        res_valid;
  logic        res_ready;
  logic        out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_limit   <= LOW_LIMIT_RST;
      cfg_q.upper_limit <= UPPER_LIMIT_RST;
      cfg_q.range_start <= RANGE_START_RST;
      cfg_q.range_end   <= RANGE_END_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOW_LIMIT:   cfg_q.low_limit   <= cfg_wdata_i;
        CFG_UPPER_LIMIT: cfg_q.upper_limit <= cfg_wdata_i;
        CFG_RANGE_START: cfg_q.range_start <= cfg_wdata_i;
        CFG_RANGE_END:   cfg_q.range_end   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pfl_ctrl #(
    .PAGE_SIZE(PAGE_SIZE),
    .NUM_PAGES(NUM_PAGES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_action_i(s_axis_tuser),
    .in_addr_i  (s_axis_tdata),
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_q);

endmodule

[hdl/pfl_link_mem.sv]
// next-link table, one write port and one registered read port
`timescale 1ns / 1ps
module pfl_link_mem #(
  parameter int NUM_PAGES = 1024,
  parameter int IDX_W     = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  logic [IDX_W-1:0] wdata_i,
  input  logic [IDX_W-1:0] raddr_i,
  output logic [IDX_W-1:0] rdata_o
);

  logic [IDX_W-1:0] mem [NUM_PAGES];
  logic [IDX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/pfl_page_check.sv]
// shared page address check: alignment, limits and table window
`timescale 1ns / 1ps
module pfl_page_check #(
  parameter int PAGE_SIZE = 4096,
  parameter int NUM_PAGES = 1024,
  parameter int IDX_W     = 10
) (
  input  logic [pfl_pkg::ADDR_W-1:0] addr_i,
  input  logic [pfl_pkg::ADDR_W-1:0] low_limit_i,
  input  logic [pfl_pkg::ADDR_W-1:0] upper_limit_i,
  output logic                       ok_o,
  output logic [IDX_W-1:0]           idx_o
);
  import pfl_pkg::*;

  localparam int PB  = $clog2(PAGE_SIZE);
  localparam int PNW = ADDR_W - PB;
  localparam logic [PNW:0] NUM_PAGES_W = (PNW + 1)'(NUM_PAGES);

  logic [PNW-1:0] page_num;
  logic           aligned;
  logic           in_window;

  assign page_num  = addr_i[ADDR_W-1:PB];
  assign aligned   = (addr_i[PB-1:0] == '0);
  assign in_window = ({1'b0, page_num} < NUM_PAGES_W);
  assign ok_o      = aligned && in_window && (addr_i >= low_limit_i)
                     && (addr_i < upper_limit_i);
  assign idx_o     = page_num[IDX_W-1:0];

endmodule

[hdl/pfl_ctrl.sv]
// sequencer: list head, allocate, single free and range walk
`timescale 1ns / 1ps
module pfl_ctrl #(
  parameter int PAGE_SIZE = 4096,
  parameter int NUM_PAGES = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [pfl_pkg::ACT_W-1:0]   in_action_i,
  input  logic [pfl_pkg::ADDR_W-1:0]  in_addr_i,
  input  pfl_pkg::pfl_cfg_t           cfg_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output pfl_pkg::pfl_result_t        res_o
);
  import pfl_pkg::*;

  localparam int PB    = $clog2(PAGE_SIZE);
  localparam int PNW   = ADDR_W - PB;
  localparam int IDX_W = $clog2(NUM_PAGES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_FREE  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic              empty_q, empty_d;
  logic [PNW:0]      cur_q, cur_d;
  logic [PNW-1:0]    lim_q, lim_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  logic              res_got_q, res_got_d;
  logic [STAT_W-1:0] res_status_q, res_status_d;

  logic [ADDR_W-1:0] chk_addr;
  logic              chk_ok;
  logic [IDX_W-1:0]  chk_idx;
  logic              walk_more;
  logic              push;
  logic [IDX_W-1:0]  link_rdata;
  logic [IDX_W-1:0]  link_wdata;

  assign chk_addr  = (state_q == S_WALK) ? {cur_q[PNW-1:0], {PB{1'b0}}} : addr_q;
  assign walk_more = (cur_q < {1'b0, lim_q});
  assign push      = chk_ok && ((state_q == S_FREE) || ((state_q == S_WALK) && walk_more));
  assign link_wdata = empty_q ? chk_idx : head_q;

  pfl_page_check #(
    .PAGE_SIZE(PAGE_SIZE),
    .NUM_PAGES(NUM_PAGES),
    .IDX_W    (IDX_W)
  ) u_check (
    .addr_i       (chk_addr),
    .low_limit_i  (cfg_i.low_limit),
    .upper_limit_i(cfg_i.upper_limit),
    .ok_o         (chk_ok),
    .idx_o        (chk_idx)
  );

  pfl_link_mem #(
    .NUM_PAGES(NUM_PAGES),
    .IDX_W    (IDX_W)
  ) u_link_mem (
    .clk_i  (clk_i),
    .we_i   (push),
    .waddr_i(chk_idx),
    .wdata_i(link_wdata),
    .raddr_i(head_q),
    .rdata_o(link_rdata)
  );

  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    head_d       = head_q;
    empty_d      = empty_q;
    cur_d        = cur_q;
    lim_d        = lim_q;
    res_addr_d   = res_addr_q;
    res_got_d    = res_got_q;
    res_status_d = res_status_q;
    in_ready_o   = 1'b0;
    res_valid_o  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_addr_d   = '0;
          res_got_d    = 1'b0;
          res_status_d = ST_OK;
          case (in_action_i)
            ACT_ALLOC: begin
              if (empty_q) begin
                res_status_d = ST_NO_PAGE;
                state_d      = S_DONE;
              end else begin
                state_d = S_ALLOC;
              end
            end
            ACT_FREE: begin
              addr_d  = in_addr_i;
              state_d = S_FREE;
            end
            ACT_RANGE: begin
              cur_d = {1'b0, cfg_i.range_start[ADDR_W-1:PB]}
                      + (PNW + 1)'(cfg_i.range_start[PB-1:0] != '0);
              lim_d   = cfg_i.range_end[ADDR_W-1:PB];
              state_d = S_WALK;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_ALLOC: begin
        res_addr_d = {PNW'(head_q), {PB{1'b0}}};
        res_got_d  = 1'b1;
        if (link_rdata == head_q) begin
          empty_d = 1'b1;
        end else begin
          head_d = link_rdata;
        end
        state_d = S_DONE;
      end
      S_FREE: begin
        if (!chk_ok) begin
          res_status_d = ST_BAD;
        end
        state_d = S_DONE;
      end
      S_WALK: begin
        if (walk_more) begin
          if (!chk_ok) begin
            res_status_d = ST_BAD;
          end
          cur_d = cur_q + (PNW + 1)'(1);
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (push) begin
      head_d  = chk_idx;
      empty_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      empty_q <= 1'b1;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      empty_q <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q       <= addr_d;
    cur_q        <= cur_d;
    lim_q        <= lim_d;
    res_addr_q   <= res_addr_d;
    res_got_q    <= res_got_d;
    res_status_q <= res_status_d;
  end

  assign res_o.alloc_addr = res_addr_q;
  assign res_o.got_page   = res_got_q;
  assign res_o.status     = res_status_q;

endmodule

[hdl/pfl_checker.sv]
// port-level assertions for the page free list allocator, with bind
`timescale 1ns / 1ps
module pfl_checker #(
  parameter int PAGE_SIZE = 4096
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [pfl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import pfl_pkg::*;

  localparam int PB = $clog2(PAGE_SIZE);

  logic [ADDR_W-1:0] o_addr;
  logic              o_got;
  logic [STAT_W-1:0] o_status;

  assign o_addr   = m_axis_tdata[ADDR_W-1:0];
  assign o_got    = m_axis_tdata[ADDR_W];
  assign o_status = m_axis_tdata[ADDR_W+STAT_W:ADDR_W+1];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while previous one in work");

  a_got_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && o_got |-> (o_status == ST_OK) && (o_addr[PB-1:0] == '0))
    else $error("allocated page with bad status or misaligned address");

  a_no_got_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !o_got |-> (o_addr == '0) && (o_status != ST_NO_PAGE || !o_got))
    else $error("address given without a page");

endmodule

bind page_free_list_allocator pfl_checker #(
  .PAGE_SIZE(PAGE_SIZE)
) u_pfl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
